// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// Tokenizer package
// Payload types, token codes, result kinds and character class functions.
// ----------------------------------------------------------------------------
package cst_pkg;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [6:0]  token_code;
      logic [31:0] token_start;
      logic [15:0] token_length;
      logic        last_result;
   } rsp_type;

   // Result kinds.
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Token codes. Keywords take codes 1 to 32 in table order.
   localparam logic [6:0] TK_NONE    = 7'd0;
   localparam logic [6:0] TK_PLUS    = 7'd33;
   localparam logic [6:0] TK_MINUS   = 7'd34;
   localparam logic [6:0] TK_STAR    = 7'd35;
   localparam logic [6:0] TK_SLASH   = 7'd36;
   localparam logic [6:0] TK_LT      = 7'd37;
   localparam logic [6:0] TK_LE      = 7'd38;
   localparam logic [6:0] TK_GT      = 7'd39;
   localparam logic [6:0] TK_GE      = 7'd40;
   localparam logic [6:0] TK_ASSIGN  = 7'd41;
   localparam logic [6:0] TK_EQ      = 7'd42;
   localparam logic [6:0] TK_NE      = 7'd43;
   localparam logic [6:0] TK_SEMI    = 7'd44;
   localparam logic [6:0] TK_LPAREN  = 7'd45;
   localparam logic [6:0] TK_RPAREN  = 7'd46;
   localparam logic [6:0] TK_CARET   = 7'd47;
   localparam logic [6:0] TK_COMMA   = 7'd48;
   localparam logic [6:0] TK_DQUOTE  = 7'd49;
   localparam logic [6:0] TK_SQUOTE  = 7'd50;
   localparam logic [6:0] TK_HASH    = 7'd51;
   localparam logic [6:0] TK_AMP     = 7'd52;
   localparam logic [6:0] TK_ANDAND  = 7'd53;
   localparam logic [6:0] TK_PIPE    = 7'd54;
   localparam logic [6:0] TK_OROR    = 7'd55;
   localparam logic [6:0] TK_PERCENT = 7'd56;
   localparam logic [6:0] TK_TILDE   = 7'd57;
   localparam logic [6:0] TK_SHL     = 7'd58;
   localparam logic [6:0] TK_SHR     = 7'd59;
   localparam logic [6:0] TK_LBRACK  = 7'd60;
   localparam logic [6:0] TK_RBRACK  = 7'd61;
   localparam logic [6:0] TK_LBRACE  = 7'd62;
   localparam logic [6:0] TK_RBRACE  = 7'd63;
   localparam logic [6:0] TK_BSLASH  = 7'd64;
   localparam logic [6:0] TK_DOT     = 7'd65;
   localparam logic [6:0] TK_QUEST   = 7'd66;
   localparam logic [6:0] TK_COLON   = 7'd67;
   localparam logic [6:0] TK_BANG    = 7'd68;
   localparam logic [6:0] TK_INC     = 7'd69;
   localparam logic [6:0] TK_DEC     = 7'd70;
   localparam logic [6:0] TK_IDENT   = 7'd71;
   localparam logic [6:0] TK_NUMBER  = 7'd72;

   localparam int KW_COUNT = 32;
   localparam int KW_MAX   = 8;

   // Keyword text, right aligned: the first character sits in the highest used byte.
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
      "while"};

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
      4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
      4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
      4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5};

   // Result queue size; an item may leave two results.
   localparam int RSP_DEPTH = 4;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == " " || c == 8'h0A || c == 8'h00;
   endfunction

   function automatic logic [6:0] single_code(input logic [7:0] c);
      logic [6:0] code;
      case (c)
         "*":     code = TK_STAR;
         "/":     code = TK_SLASH;
         ";":     code = TK_SEMI;
         "(":     code = TK_LPAREN;
         ")":     code = TK_RPAREN;
         "^":     code = TK_CARET;
         ",":     code = TK_COMMA;
         8'h22:   code = TK_DQUOTE;
         8'h27:   code = TK_SQUOTE;
         "#":     code = TK_HASH;
         "%":     code = TK_PERCENT;
         "~":     code = TK_TILDE;
         "[":     code = TK_LBRACK;
         "]":     code = TK_RBRACK;
         "{":     code = TK_LBRACE;
         "}":     code = TK_RBRACE;
         8'h5C:   code = TK_BSLASH;
         ".":     code = TK_DOT;
         "?":     code = TK_QUEST;
         ":":     code = TK_COLON;
         default: code = TK_NONE;
      endcase
      return code;
   endfunction

   // Code of an operator that may take a second character, standing alone.
   function automatic logic [6:0] lead_code(input logic [7:0] c);
      logic [6:0] code;
      case (c)
         "<":     code = TK_LT;
         ">":     code = TK_GT;
         "=":     code = TK_ASSIGN;
         "+":     code = TK_PLUS;
         "-":     code = TK_MINUS;
         "!":     code = TK_BANG;
         "&":     code = TK_AMP;
         "|":     code = TK_PIPE;
         default: code = TK_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [6:0] pair_code(input logic [7:0] a, input logic [7:0] b);
      logic [6:0] code;
      case ({a, b})
         "<=":    code = TK_LE;
         "<<":    code = TK_SHL;
         ">=":    code = TK_GE;
         ">>":    code = TK_SHR;
         "==":    code = TK_EQ;
         "++":    code = TK_INC;
         "--":    code = TK_DEC;
         "!=":    code = TK_NE;
         "&&":    code = TK_ANDAND;
         "||":    code = TK_OROR;
         default: code = TK_NONE;
      endcase
      return code;
   endfunction

   // Keyword lookup. chars holds the first eight characters, the first one in
   // the lowest byte; only bytes below len are compared.
   function automatic logic [6:0] keyword_code(input logic [63:0] chars,
                                               input logic [15:0] len);
      logic [6:0] code;
      logic       hit;
      logic [2:0] pos;
      code = TK_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         hit = (len == 16'(KW_LEN[i]));
         for (int j = 0; j < KW_MAX; j++) begin
            pos = 3'(int'(KW_LEN[i]) + KW_MAX - 1 - j);
            if (j < int'(KW_LEN[i]) && chars[8*j +: 8] != KW_TEXT[i][8*pos +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            code = 7'(i + 1);
         end
      end
      return code;
   endfunction

endpackage

// ----- rtl/c_subset_tokenizer.sv -----
// ----------------------------------------------------------------------------
// C subset tokenizer
// Turns a byte stream of C source into tokens with start offset and length.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock cycle, with no bubbles between
// bytes, as long as its four-entry result queue has room for two more
// results. Each byte is classified and the scanner state updated in the cycle
// it is accepted, and any results it completes are registered into the result
// queue. One byte can complete up to two results (a token that it ends, then
// its own single-character token, error or end marker), so a stream that
// keeps producing two results per byte is limited by the result port, which
// delivers one result per cycle unless stalled; the request side then stalls
// until the queue drains. Keyword detection compares the identifier buffer
// against all 32 keywords in parallel. After an illegal character the block
// swallows every request, end of input included, until reset.
// ----------------------------------------------------------------------------
module c_subset_tokenizer #(
   parameter int KEYWORD_CHARS = 8,
   parameter int OFFSET_BITS   = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_payload
);
   import cst_pkg::*;

   // Scanner modes.
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_IDENT  = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;
   localparam logic [1:0] MODE_OPER   = 2'd3;

   localparam int KbIdxBits = $clog2(KEYWORD_CHARS);
   localparam int PosBits   = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
   localparam int PtrBits   = $clog2(RSP_DEPTH);
   localparam int CntBits   = PtrBits + 1;
   localparam logic [15:0] LenMax = 16'hFFFF;

   // Scanner state.
   logic [1:0]             mode_ff,    mode_in;
   logic [7:0]             pend_ff,    pend_in;
   logic [15:0]            len_ff,     len_in;
   logic [31:0]            start_ff,   start_in;
   logic [OFFSET_BITS-1:0] offset_ff,  offset_in;
   logic                   halted_ff,  halted_in;
   logic [7:0]             kbuf_ff [KEYWORD_CHARS];
   logic                   kbuf_we;
   logic [KbIdxBits-1:0]   kbuf_idx;

   // Result queue.
   rsp_type                fifo_ff [RSP_DEPTH];
   logic [PtrBits-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]     count_ff,  count_in;

   logic                   accept;
   logic                   pop;
   logic [7:0]             c;
   logic [31:0]            pos;
   logic [63:0]            kw_chars;
   logic [6:0]             flush_code;
   logic                   flush_valid;
   rsp_type                flush_res;
   logic                   new_valid;
   rsp_type                new_res;
   logic                   flush_take;
   rsp_type                res_a, res_b;
   logic [1:0]             n_res;
   logic [6:0]             pair;

   assign accept    = req_valid & ~req_stall;
   assign pop       = rsp_valid & ~rsp_stall;
   assign req_stall = count_ff > CntBits'(RSP_DEPTH - 2);
   assign rsp_valid = count_ff != '0;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

   assign c    = req_payload.char_in;
   assign pos  = 32'(offset_ff[PosBits-1:0]);
   assign pair = pair_code(pend_ff, c);

   always_comb begin
      for (int j = 0; j < KW_MAX; j++) begin
         kw_chars[8*j +: 8] = kbuf_ff[j];
      end
   end

   // The token that the current mode would report if it ended now.
   always_comb begin
      case (mode_ff)
         MODE_IDENT:  flush_code = (len_ff > 16'(KEYWORD_CHARS)) ? TK_IDENT
                                                                : keyword_code(kw_chars, len_ff);
         MODE_NUMBER: flush_code = TK_NUMBER;
         MODE_OPER:   flush_code = lead_code(pend_ff);
         default:     flush_code = TK_NONE;
      endcase
      flush_valid = mode_ff != MODE_IDLE;
      flush_res   = '{result_kind: KIND_TOKEN, token_code: flush_code,
                      token_start: start_ff, token_length: len_ff, last_result: 1'b0};
   end

   // Scanner next state and the results of the accepted byte. When a byte
   // ends the token in progress, that token is reported first and the byte
   // is then handled as if no token were in progress.
   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      len_in     = len_ff;
      start_in   = start_ff;
      offset_in  = offset_ff;
      halted_in  = halted_ff;
      kbuf_we    = 1'b0;
      kbuf_idx   = len_ff[KbIdxBits-1:0];
      flush_take = 1'b0;
      new_valid  = 1'b0;
      new_res    = '{result_kind: KIND_TOKEN, token_code: TK_NONE,
                     token_start: pos, token_length: 16'd1, last_result: 1'b0};

      if (accept && !halted_ff) begin
         if (req_payload.end_of_input) begin
            flush_take = flush_valid;
            new_valid  = 1'b1;
            new_res.result_kind  = KIND_END;
            new_res.token_length = '0;
            mode_in   = MODE_IDLE;
            pend_in   = '0;
            len_in    = '0;
            start_in  = '0;
            offset_in = '0;
         end else begin
            offset_in = offset_ff + OFFSET_BITS'(1);
            if (mode_ff == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
               kbuf_we = len_ff < 16'(KEYWORD_CHARS);
               if (len_ff != LenMax) begin
                  len_in = len_ff + 16'd1;
               end
            end else if (mode_ff == MODE_NUMBER && is_digit(c)) begin
               if (len_ff != LenMax) begin
                  len_in = len_ff + 16'd1;
               end
            end else if (mode_ff == MODE_OPER && pair != TK_NONE) begin
               new_valid = 1'b1;
               new_res.token_code   = pair;
               new_res.token_start  = start_ff;
               new_res.token_length = 16'd2;
               mode_in = MODE_IDLE;
               pend_in = '0;
            end else begin
               flush_take = flush_valid;
               mode_in    = MODE_IDLE;
               pend_in    = '0;
               start_in   = pos;
               len_in     = 16'd1;
               if (is_blank(c)) begin
                  mode_in = MODE_IDLE;
               end else if (is_letter(c)) begin
                  mode_in  = MODE_IDENT;
                  kbuf_we  = 1'b1;
                  kbuf_idx = '0;
               end else if (is_digit(c)) begin
                  mode_in = MODE_NUMBER;
               end else if (single_code(c) != TK_NONE) begin
                  new_valid = 1'b1;
                  new_res.token_code = single_code(c);
               end else if (lead_code(c) != TK_NONE) begin
                  mode_in = MODE_OPER;
                  pend_in = c;
               end else begin
                  new_valid = 1'b1;
                  new_res.result_kind = KIND_ERROR;
                  halted_in = 1'b1;
               end
            end
         end
      end
   end

   // Order the results and flag the final one of this byte.
   always_comb begin
      res_a = flush_res;
      res_b = new_res;
      res_b.last_result = 1'b1;
      n_res = 2'd0;
      if (flush_take && new_valid) begin
         n_res = 2'd2;
      end else if (flush_take) begin
         res_a.last_result = 1'b1;
         n_res = 2'd1;
      end else if (new_valid) begin
         res_a = res_b;
         n_res = 2'd1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(n_res);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + CntBits'(n_res) - CntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pend_ff   <= '0;
         len_ff    <= '0;
         start_ff  <= '0;
         offset_ff <= '0;
         halted_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         len_ff    <= len_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         halted_ff <= halted_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Identifier characters and queued results carry no reset.
   always_ff @(posedge clock) begin
      if (kbuf_we) begin
         kbuf_ff[kbuf_idx] <= c;
      end
      if (n_res != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res_a;
      end
      if (n_res == 2'd2) begin
         fifo_ff[wr_ptr_ff + PtrBits'(1)] <= res_b;
      end
   end

endmodule

// ----- rtl/cst_checker.sv -----
// ----------------------------------------------------------------------------
// Tokenizer checker
// Port-level assertions on the result channel, bound into the tokenizer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cst_pkg::rsp_type rsp_payload
);
   import cst_pkg::*;

   // A stalled result stays offered and unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "result changed while stalled")

   // Every token carries a code from the token table and a nonzero length.
   `ASSERT_SAME(a_token_code, clock, reset, rsp_valid && rsp_payload.result_kind == KIND_TOKEN, rsp_payload.token_code != TK_NONE && rsp_payload.token_code <= TK_NUMBER && rsp_payload.token_length != 16'd0, "token without a valid code or length")

   // End markers and errors carry no code and close the transaction's results.
   `ASSERT_SAME(a_marker_last, clock, reset, rsp_valid && (rsp_payload.result_kind == KIND_END || rsp_payload.result_kind == KIND_ERROR), rsp_payload.token_code == TK_NONE && rsp_payload.last_result, "marker with code or not last")

   // No result kind beyond the three defined ones.
   `ASSERT_SAME(a_kind_known, clock, reset, rsp_valid, rsp_payload.result_kind != 2'd3, "undefined result kind")

endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (.*);

// ----- verif/c_subset_tokenizer_test.sv -----
// ----------------------------------------------------------------------------
// C subset tokenizer testbench
// Feeds byte streams of C-like text through the tokenizer with random bursts,
// gaps and result-side stalls, and compares every token, end marker and error
// against a cycle-free software tokenizer kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_test;
   import cst_pkg::*;

   // Cycles without any accepted transaction before the run is declared hung.
   // The longest legal quiet stretch is the deliberate receiver hold-off below.
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_BYTES = 1030;
   localparam int LONG_WORD    = 40;
   localparam int WORD_KEEP    = 8;
   localparam logic [15:0] LEN_CAP = 16'hFFFF;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_OP} scan_type;
   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE} rx_style_type;

   // One source transaction of the directed script. Rows with typed set carry
   // the final result of that byte written out by hand; all other rows, and
   // the random stream, take their expectations from the software tokenizer.
   typedef struct packed {
      logic [7:0]  ch;
      logic        eoi;
      logic        typed;
      logic [1:0]  kind;
      logic [6:0]  code;
      logic [31:0] start;
      logic [15:0] len;
   } script_row_type;

   localparam int SCRIPT_ROWS = 25;
   localparam int TAIL_FROM   = 19;

   // The head runs right after reset. The tail runs last of all, since the
   // illegal byte in it halts the block for the rest of the run.
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // End of input straight out of reset: marker at offset zero.
      '{8'h00, 1'b1, 1'b1, KIND_END,   TK_NONE, 32'd0, 16'd0},
      '{8'h00, 1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"i",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"f",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"<",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"=",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"9",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"!",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      // A blank right after a lookahead character ends it as a lone operator.
      '{" ",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"=",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{";",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"&",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"&",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"|",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"+",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"+",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"Z",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"7",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{8'h0A, 1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      // Tail: a fresh stream, an identifier cut short by a byte above 127.
      '{8'h00, 1'b1, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"w",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{"9",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{8'hFF, 1'b0, 1'b1, KIND_ERROR, TK_NONE, 32'd2, 16'd1},
      // Once halted, neither bytes nor end of input produce anything.
      '{"a",   1'b0, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0},
      '{8'h00, 1'b1, 1'b0, KIND_TOKEN, TK_NONE, 32'd0, 16'd0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   c_subset_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   string keywords [32] = '{
      "auto", "break", "case", "char", "const", "continue", "default", "do",
      "double", "else", "enum", "extern", "float", "for", "goto", "if",
      "int", "long", "register", "return", "short", "signed", "sizeof", "static",
      "struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
      "while"};
   string solo_chars = "*/;()^,\"'#%~[]{}\\.?:";
   string lead_chars = "<>=+-!&|";

   // Software tokenizer state, advanced once per accepted source transaction.
   scan_type    lx_mode   = SCAN_IDLE;
   logic [7:0]  lx_pend   = 8'd0;
   logic [7:0]  lx_word [WORD_KEEP];
   logic [15:0] lx_len    = 16'd0;
   logic [31:0] lx_start  = 32'd0;
   logic [31:0] lx_offset = 32'd0;
   bit          lx_halted = 1'b0;
   rsp_type     lx_out [2];
   int          lx_n;

   rsp_type    tokens_due [$];
   logic [7:0] frag [$];

   int  errors       = 0;
   int  bytes_fed    = 0;
   int  ends_fed     = 0;
   int  results_seen = 0;
   int  keyword_hits = 0;
   int  burst_left   = 0;
   int  quiet_cycles = 0;
   bit  hold_due     = 1'b0;

   // ---------------------------------------------------------------------
   // Character classes and operator codes.
   // ---------------------------------------------------------------------
   function automatic bit cls_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit cls_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit cls_blank(input logic [7:0] c);
      return c == " " || c == 8'h0A || c == 8'h00;
   endfunction

   function automatic logic [6:0] solo_op(input logic [7:0] c);
      case (c)
         "*":   return TK_STAR;
         "/":   return TK_SLASH;
         ";":   return TK_SEMI;
         "(":   return TK_LPAREN;
         ")":   return TK_RPAREN;
         "^":   return TK_CARET;
         ",":   return TK_COMMA;
         8'h22: return TK_DQUOTE;   // double quote
         8'h27: return TK_SQUOTE;   // single quote
         "#":   return TK_HASH;
         "%":   return TK_PERCENT;
         "~":   return TK_TILDE;
         "[":   return TK_LBRACK;
         "]":   return TK_RBRACK;
         "{":   return TK_LBRACE;
         "}":   return TK_RBRACE;
         8'h5C: return TK_BSLASH;   // backslash
         ".":   return TK_DOT;
         "?":   return TK_QUEST;
         ":":   return TK_COLON;
         default: return TK_NONE;
      endcase
   endfunction

   // Operators that look one byte ahead, as they stand when nothing follows.
   function automatic logic [6:0] lead_op(input logic [7:0] c);
      case (c)
         "<": return TK_LT;
         ">": return TK_GT;
         "=": return TK_ASSIGN;
         "+": return TK_PLUS;
         "-": return TK_MINUS;
         "!": return TK_BANG;
         "&": return TK_AMP;
         "|": return TK_PIPE;
         default: return TK_NONE;
      endcase
   endfunction

   function automatic logic [6:0] pair_op(input logic [7:0] a, input logic [7:0] b);
      if (a == "<" && b == "=") return TK_LE;
      if (a == "<" && b == "<") return TK_SHL;
      if (a == ">" && b == "=") return TK_GE;
      if (a == ">" && b == ">") return TK_SHR;
      if (a == "=" && b == "=") return TK_EQ;
      if (a == "+" && b == "+") return TK_INC;
      if (a == "-" && b == "-") return TK_DEC;
      if (a == "!" && b == "=") return TK_NE;
      if (a == "&" && b == "&") return TK_ANDAND;
      if (a == "|" && b == "|") return TK_OROR;
      return TK_NONE;
   endfunction

   function automatic bit cls_legal(input logic [7:0] c);
      return cls_blank(c) || cls_letter(c) || cls_digit(c) ||
             solo_op(c) != TK_NONE || lead_op(c) != TK_NONE;
   endfunction

   // ---------------------------------------------------------------------
   // Software tokenizer.
   // ---------------------------------------------------------------------
   function automatic void lx_emit(input logic [1:0] kind, input logic [6:0] code,
                                   input logic [31:0] start, input logic [15:0] len);
      lx_out[lx_n].result_kind  = kind;
      lx_out[lx_n].token_code   = code;
      lx_out[lx_n].token_start  = start;
      lx_out[lx_n].token_length = len;
      lx_out[lx_n].last_result  = 1'b0;
      lx_n++;
   endfunction

   // Identifiers longer than the kept prefix can never be keywords.
   function automatic logic [6:0] word_code();
      int i;
      int j;
      bit same;
      if (lx_len > WORD_KEEP) return TK_IDENT;
      for (i = 0; i < 32; i++) begin
         if (keywords[i].len() == int'(lx_len)) begin
            same = 1'b1;
            for (j = 0; j < keywords[i].len(); j++) begin
               if (lx_word[j] != keywords[i][j]) same = 1'b0;
            end
            if (same) return 7'(i + 1);
         end
      end
      return TK_IDENT;
   endfunction

   // Closes whatever token is in progress.
   function automatic void lx_flush();
      case (lx_mode)
         SCAN_WORD: lx_emit(KIND_TOKEN, word_code(), lx_start, lx_len);
         SCAN_NUM:  lx_emit(KIND_TOKEN, TK_NUMBER, lx_start, lx_len);
         SCAN_OP:   lx_emit(KIND_TOKEN, lead_op(lx_pend), lx_start, lx_len);
         default:   ;
      endcase
      lx_mode = SCAN_IDLE;
      lx_pend = 8'd0;
   endfunction

   // Opens a token with byte c at offset pos, or reports c as illegal.
   function automatic void lx_open(input logic [7:0] c, input logic [31:0] pos);
      lx_start = pos;
      lx_len   = 16'd1;
      if (cls_blank(c)) return;
      if (cls_letter(c)) begin
         lx_mode    = SCAN_WORD;
         lx_word[0] = c;
      end else if (cls_digit(c)) begin
         lx_mode = SCAN_NUM;
      end else if (solo_op(c) != TK_NONE) begin
         lx_emit(KIND_TOKEN, solo_op(c), pos, 16'd1);
      end else if (lead_op(c) != TK_NONE) begin
         lx_mode = SCAN_OP;
         lx_pend = c;
      end else begin
         lx_emit(KIND_ERROR, TK_NONE, pos, 16'd1);
         lx_halted = 1'b1;
      end
   endfunction

   // Advances the tokenizer by one source transaction; the results it causes
   // land in lx_out[0 .. lx_n-1], the last one flagged.
   function automatic void lex_step(input logic [7:0] c, input logic eoi);
      logic [31:0] pos;
      logic [6:0]  paired;
      lx_n = 0;
      pos  = lx_offset;
      if (lx_halted) return;
      if (eoi) begin
         lx_flush();
         lx_emit(KIND_END, TK_NONE, pos, 16'd0);
         lx_offset = 32'd0;
         lx_len    = 16'd0;
         lx_start  = 32'd0;
      end else begin
         lx_offset = lx_offset + 32'd1;
         paired    = pair_op(lx_pend, c);
         if (lx_mode == SCAN_WORD && (cls_letter(c) || cls_digit(c))) begin
            if (lx_len < WORD_KEEP) lx_word[lx_len] = c;
            if (lx_len != LEN_CAP) lx_len++;
         end else if (lx_mode == SCAN_NUM && cls_digit(c)) begin
            if (lx_len != LEN_CAP) lx_len++;
         end else if (lx_mode == SCAN_OP && paired != TK_NONE) begin
            lx_emit(KIND_TOKEN, paired, lx_start, 16'd2);
            lx_mode = SCAN_IDLE;
            lx_pend = 8'd0;
         end else begin
            lx_flush();
            lx_open(c, pos);
         end
      end
      if (lx_n > 0) lx_out[lx_n - 1].last_result = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Random text generation.
   // ---------------------------------------------------------------------
   function automatic void frag_add(input logic [7:0] ch);
      frag = {frag, ch};
   endfunction

   function automatic logic [7:0] any_letter();
      if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] any_alnum();
      if ($urandom_range(0, 3) == 0) return 8'("0" + $urandom_range(0, 9));
      return any_letter();
   endfunction

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 2))
         0:       return " ";
         1:       return 8'h0A;
         default: return 8'h00;
      endcase
   endfunction

   // Any byte the block accepts without halting, drawn from 0 to 127.
   function automatic logic [7:0] any_legal();
      logic [7:0] c;
      c = 8'($urandom_range(0, 127));
      while (!cls_legal(c)) c = 8'($urandom_range(0, 127));
      return c;
   endfunction

   // Appends one well-formed piece of C-like text to frag. Most pieces are
   // real tokens so that keywords, pairs and long runs are reached often;
   // a few are loose noise. A piece may abut the next one with no blank.
   function automatic void add_fragment();
      int    pick;
      int    n;
      int    i;
      string w;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         w = keywords[$urandom_range(0, 31)];
         n = w.len();
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
         for (i = 0; i < n; i++) frag_add(w[i]);
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) frag_add(any_alnum());
         end
      end else if (pick < 40) begin
         frag_add(any_letter());
         repeat ($urandom_range(0, 11)) frag_add(any_alnum());
      end else if (pick < 52) begin
         repeat ($urandom_range(1, 6)) frag_add(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 64) begin
         frag_add(solo_chars[$urandom_range(0, solo_chars.len() - 1)]);
      end else if (pick < 80) begin
         c = lead_chars[$urandom_range(0, lead_chars.len() - 1)];
         frag_add(c);
         if ($urandom_range(0, 1) == 0) frag_add(($urandom_range(0, 1) == 0) ? "=" : c);
      end else if (pick < 92) begin
         repeat ($urandom_range(1, 3)) frag_add(any_blank());
      end else begin
         repeat ($urandom_range(1, 3)) frag_add(any_legal());
      end
      if ($urandom_range(0, 1) == 0) frag_add(any_blank());
   endfunction

   // ---------------------------------------------------------------------
   // Source side. The sender works in bursts of random length and idles for
   // a random number of cycles between bursts. A transaction is offered at a
   // rising edge and held, unchanged, until an edge sees stall low.
   // ---------------------------------------------------------------------
   task automatic offer(input req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // Sends one transaction and books the results it must cause. A script row
   // with a typed result replaces the last predicted result with that value.
   task automatic feed(input script_row_type row);
      req_type item;
      int      k;
      item.char_in      = row.ch;
      item.end_of_input = row.eoi;
      offer(item);
      lex_step(row.ch, row.eoi);
      if (row.typed && lx_n > 0) begin
         lx_out[lx_n - 1].result_kind  = row.kind;
         lx_out[lx_n - 1].token_code   = row.code;
         lx_out[lx_n - 1].token_start  = row.start;
         lx_out[lx_n - 1].token_length = row.len;
         lx_out[lx_n - 1].last_result  = 1'b1;
      end
      for (k = 0; k < lx_n; k++) tokens_due = {tokens_due, lx_out[k]};
      bytes_fed++;
      if (row.eoi) ends_fed++;
   endtask

   function automatic script_row_type plain(input logic [7:0] c, input logic eoi);
      script_row_type row;
      row     = '0;
      row.ch  = c;
      row.eoi = eoi;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus: directed script head, random text, one long identifier,
   // then the script tail that ends in a halt.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int r;
      int sent;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < TAIL_FROM; r++) feed(SCRIPT[r]);

      // The receiver takes its long hold-off while this stream is running,
      // so the result queue fills and the block has to stall its input.
      hold_due = 1'b1;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 49) == 0) begin
            // The byte is ignored with end of input, so any value may ride along.
            feed(plain(8'($urandom_range(0, 255)), 1'b1));
            sent++;
         end else begin
            add_fragment();
            while (frag.size() > 0) begin
               feed(plain(frag.pop_front(), 1'b0));
               sent++;
            end
         end
      end

      // An identifier well past the kept keyword prefix.
      feed(plain("x", 1'b0));
      repeat (LONG_WORD) feed(plain(any_alnum(), 1'b0));
      feed(plain(" ", 1'b0));

      for (r = TAIL_FROM; r < SCRIPT_ROWS; r++) feed(SCRIPT[r]);
      req_valid <= 1'b0;

      while (tokens_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Fed %0d source bytes (%0d end-of-input transactions); checked %0d results, %0d keywords.",
               bytes_fed, ends_fed, results_seen, keyword_hits);
      $display("Stream had directed operators, random text, a %0d-character identifier and a halt.",
               LONG_WORD + 1);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side. The receiver stalls on a pattern of its own: segments of
   // random length that are open, lightly stalled, heavily stalled or
   // alternating, plus one long hold-off once the random stream is running.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int           seg;
      int           k;
      rx_style_type style;
      forever begin
         if (hold_due) begin
            hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         seg   = $urandom_range(10, 120);
         style = rx_style_type'($urandom_range(0, 3));
         for (k = 0; k < seg; k++) begin
            case (style)
               RX_OPEN:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:  rsp_stall <= k[0];
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endtask

   // Every accepted result is held against the oldest outstanding one.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = rsp_payload;
         results_seen++;
         if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
         end else begin
            want = tokens_due.pop_front();
            if (got.result_kind !== want.result_kind)
               flag("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            if (got.token_code !== want.token_code)
               flag("token_code", 32'(want.token_code), 32'(got.token_code));
            if (got.token_start !== want.token_start)
               flag("token_start", want.token_start, got.token_start);
            if (got.token_length !== want.token_length)
               flag("token_length", 32'(want.token_length), 32'(got.token_length));
            if (got.last_result !== want.last_result)
               flag("last_result", 32'(want.last_result), 32'(got.last_result));
            if (want.result_kind == KIND_TOKEN && want.token_code != TK_NONE &&
                want.token_code < TK_PLUS) keyword_hits++;
         end
      end
   end

   // Watchdog: a run that goes quiet on both channels for too long is hung.
   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, tokens_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule
